@@ hdl/pur_pkg.sv @@
// Shared types and constants for the picture unit register block.
`default_nettype none

package pur_pkg;

  // Item opcodes as they arrive on the input channel
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_READ       = 3'd1;
  localparam logic [2:0] OP_WRITE      = 3'd2;
  localparam logic [2:0] OP_DMA        = 3'd3;
  localparam logic [2:0] OP_SOFT_RESET = 3'd4;

  // Classified command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_READ,
    CMD_WRITE,
    CMD_DMA,
    CMD_SOFT_RESET,
    CMD_NOP
  } cmd_kind_t;

  // CPU-visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_sel_t;

  typedef struct packed {
    cmd_kind_t  kind;
    reg_sel_t   reg_sel;
    logic [7:0] data;          // write byte, or DMA page for the latch
    logic [7:0] sprite_index;  // DMA target entry
    logic [7:0] sprite_byte;   // DMA byte
  } cmd_t;

  // Command queue geometry
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Register constants
  localparam int         SPRITE_DEPTH   = 256;
  localparam logic [7:0] STATUS_RESET   = 8'hA0;
  localparam int         VBLANK_BIT     = 7;
  localparam int         CTRL_INC32_BIT = 2;
  localparam logic [7:0] MASK_RENDER    = 8'h14;
  localparam logic [15:0] STEP_WIDE     = 16'd32;
  localparam logic [15:0] STEP_NARROW   = 16'd1;

  // Timing constants
  localparam logic [8:0]        LAST_DOT    = 9'd340;
  localparam logic [8:0]        FLAG_DOT    = 9'd1;
  localparam logic signed [9:0] VBLANK_LINE = 10'sd241;
  localparam logic signed [9:0] PRE_LINE    = -10'sd1;

endpackage

`default_nettype wire

@@ hdl/pur_in_if.sv @@
// Input channel: one bus item per transfer.
`default_nettype none

interface pur_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] dma_index;
  logic [7:0] dma_byte;
  logic [7:0] dma_page;

  modport source (
    output valid, opcode, reg_index, write_data, dma_index, dma_byte, dma_page,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_index, write_data, dma_index, dma_byte, dma_page,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pur_out_if.sv @@
// Output channel: one result per transfer.
`default_nettype none

interface pur_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic              vblank;
  logic signed [9:0] scan_line;
  logic [8:0]        dot;
  logic              rendering_enabled;

  modport source (
    output valid, read_data, vblank, scan_line, dot, rendering_enabled,
    input  ready
  );
  modport sink (
    input  valid, read_data, vblank, scan_line, dot, rendering_enabled,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pur_front.sv @@
// Front end: accepts bus items and classifies them into queue commands.
`default_nettype none

module pur_front (
  pur_in_if.sink        item,
  input  logic          q_full,
  output logic          push,
  output pur_pkg::cmd_t push_cmd
);
  import pur_pkg::*;

  // Accept whenever the queue has room
  assign item.ready = !q_full;
  assign push       = item.valid && !q_full;

  // Classify the opcode and pick the payload the back end needs
  always_comb begin
    push_cmd.reg_sel      = reg_sel_t'(item.reg_index);
    push_cmd.data         = item.write_data;
    push_cmd.sprite_index = item.dma_index;
    push_cmd.sprite_byte  = item.dma_byte;
    unique case (item.opcode)
      OP_TICK:       push_cmd.kind = CMD_TICK;
      OP_READ:       push_cmd.kind = CMD_READ;
      OP_WRITE:      push_cmd.kind = CMD_WRITE;
      OP_DMA: begin
        push_cmd.kind = CMD_DMA;
        push_cmd.data = item.dma_page;
      end
      OP_SOFT_RESET: push_cmd.kind = CMD_SOFT_RESET;
      default:       push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/pur_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module pur_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pur_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pur_pkg::cmd_t head_cmd
);
  import pur_pkg::*;

  localparam logic [QUEUE_CNT_BITS-1:0] CntOne = QUEUE_CNT_BITS'(1);
  localparam logic [QUEUE_PTR_BITS-1:0] PtrOne = QUEUE_PTR_BITS'(1);

  cmd_t                      entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full       = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrOne;
      if (pop)  rd_ptr <= rd_ptr + PtrOne;
      if (push && !pop)      count <= count + CntOne;
      else if (!push && pop) count <= count - CntOne;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CntOne)
    else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

@@ hdl/pur_back.sv @@
// Back end: register file, video and sprite stores, dot timing, result register.
`default_nettype none

module pur_back #(
  parameter int VIDEO_ADDR_BITS = 14,
  parameter int LAST_LINE       = 260
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  pur_pkg::cmd_t cmd,
  output logic          pop,
  pur_out_if.source     result
);
  import pur_pkg::*;

  localparam int                VideoDepth = 1 << VIDEO_ADDR_BITS;
  localparam logic signed [9:0] LastLine   = 10'(LAST_LINE);

  // Architectural state
  logic [7:0]        control_reg, control_reg_next;
  logic [7:0]        mask_reg, mask_reg_next;
  logic [7:0]        status_reg, status_reg_next;
  logic [7:0]        sprite_addr, sprite_addr_next;
  logic [7:0]        sprite_data_last, sprite_data_last_next;
  logic [15:0]       scroll_word, scroll_word_next;
  logic [15:0]       video_addr, video_addr_next;
  logic [7:0]        bus_latch, bus_latch_next;
  logic              latch_is_mem, latch_is_mem_next;  // latch lives in mem_q
  logic              first_write, first_write_next;
  logic signed [9:0] line_count, line_count_next;
  logic [8:0]        dot_count, dot_count_next;

  // Stores
  logic [7:0] video_store [VideoDepth];
  logic [7:0] sprite_store [SPRITE_DEPTH];
  logic [7:0] mem_q;

  // Result register
  logic              res_valid;
  logic [7:0]        res_data;
  logic              res_use_mem;
  logic              res_vblank;
  logic signed [9:0] res_line;
  logic [8:0]        res_dot;
  logic              res_render;

  // Per-command control
  logic                       vid_we, vid_re, spr_we;
  logic [VIDEO_ADDR_BITS-1:0] vid_waddr, vid_raddr;
  logic [7:0]                 spr_addr, spr_wdata;
  logic [7:0]                 latch_eff, rd_value, res_data_next;
  logic                       use_mem;
  logic [15:0]                addr_stepped;

  assign pop          = cmd_valid && (!res_valid || result.ready);
  assign latch_eff    = latch_is_mem ? mem_q : bus_latch;
  assign addr_stepped = video_addr + (control_reg[CTRL_INC32_BIT] ? STEP_WIDE : STEP_NARROW);
  assign vid_waddr    = video_addr[VIDEO_ADDR_BITS-1:0];
  assign vid_raddr    = addr_stepped[VIDEO_ADDR_BITS-1:0];

  // Execute one command
  always_comb begin
    control_reg_next      = control_reg;
    mask_reg_next         = mask_reg;
    status_reg_next       = status_reg;
    sprite_addr_next      = sprite_addr;
    sprite_data_last_next = sprite_data_last;
    scroll_word_next      = scroll_word;
    video_addr_next       = video_addr;
    bus_latch_next        = bus_latch;
    latch_is_mem_next     = latch_is_mem;
    first_write_next      = first_write;
    line_count_next       = line_count;
    dot_count_next        = dot_count;
    vid_we                = 1'b0;
    vid_re                = 1'b0;
    spr_we                = 1'b0;
    spr_addr              = cmd.sprite_index;
    spr_wdata             = cmd.sprite_byte;
    rd_value              = latch_eff;
    use_mem               = 1'b0;

    unique case (cmd.kind)
      CMD_TICK: begin
        if (dot_count == LAST_DOT) begin
          dot_count_next  = '0;
          line_count_next = (line_count == LastLine) ? PRE_LINE : line_count + 10'sd1;
        end else begin
          dot_count_next = dot_count + 9'd1;
        end
        if (line_count_next == VBLANK_LINE && dot_count_next == FLAG_DOT) begin
          status_reg_next[VBLANK_BIT] = 1'b1;
        end else if (line_count_next == PRE_LINE && dot_count_next == FLAG_DOT) begin
          status_reg_next[VBLANK_BIT] = 1'b0;
        end
      end
      CMD_READ: begin
        unique case (cmd.reg_sel)
          REG_STATUS: begin
            rd_value          = status_reg;
            first_write_next  = 1'b1;
            bus_latch_next    = '0;
            latch_is_mem_next = 1'b0;
          end
          REG_OAM_DATA: begin
            rd_value          = sprite_data_last;
            bus_latch_next    = sprite_data_last;
            latch_is_mem_next = 1'b0;
          end
          REG_DATA: begin
            video_addr_next   = addr_stepped;
            vid_re            = 1'b1;
            use_mem           = 1'b1;
            latch_is_mem_next = 1'b1;
          end
          default: rd_value = latch_eff;
        endcase
      end
      CMD_WRITE: begin
        bus_latch_next    = cmd.data;
        latch_is_mem_next = 1'b0;
        unique case (cmd.reg_sel)
          REG_CTRL:     control_reg_next = cmd.data;
          REG_MASK:     mask_reg_next    = cmd.data;
          REG_STATUS:   ;
          REG_OAM_ADDR: sprite_addr_next = cmd.data;
          REG_OAM_DATA: begin
            sprite_data_last_next = cmd.data;
            spr_we                = 1'b1;
            spr_addr              = sprite_addr;
            spr_wdata             = cmd.data;
            sprite_addr_next      = sprite_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (!first_write) scroll_word_next = {latch_eff, cmd.data};
            first_write_next = !first_write;
          end
          REG_ADDR: begin
            if (!first_write) video_addr_next = {latch_eff, cmd.data};
            first_write_next = !first_write;
          end
          REG_DATA: begin
            vid_we          = 1'b1;
            video_addr_next = addr_stepped;
          end
        endcase
      end
      CMD_DMA: begin
        bus_latch_next    = cmd.data;
        latch_is_mem_next = 1'b0;
        spr_we            = 1'b1;
      end
      CMD_SOFT_RESET: begin
        control_reg_next  = '0;
        mask_reg_next     = '0;
        status_reg_next   = {status_reg[VBLANK_BIT], 7'b0};
        scroll_word_next  = '0;
        bus_latch_next    = '0;
        latch_is_mem_next = 1'b0;
        first_write_next  = 1'b1;
        line_count_next   = PRE_LINE;
        dot_count_next    = '0;
      end
      default: ;
    endcase

    // Non-read items report the latch after the step
    if (cmd.kind == CMD_READ) res_data_next = rd_value;
    else                      res_data_next = latch_is_mem_next ? mem_q : bus_latch_next;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg      <= '0;
      mask_reg         <= '0;
      status_reg       <= STATUS_RESET;
      sprite_addr      <= '0;
      sprite_data_last <= '0;
      scroll_word      <= '0;
      video_addr       <= '0;
      bus_latch        <= '0;
      latch_is_mem     <= 1'b0;
      first_write      <= 1'b1;
      line_count       <= PRE_LINE;
      dot_count        <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (pop) begin
        control_reg      <= control_reg_next;
        mask_reg         <= mask_reg_next;
        status_reg       <= status_reg_next;
        sprite_addr      <= sprite_addr_next;
        sprite_data_last <= sprite_data_last_next;
        scroll_word      <= scroll_word_next;
        video_addr       <= video_addr_next;
        bus_latch        <= bus_latch_next;
        latch_is_mem     <= latch_is_mem_next;
        first_write      <= first_write_next;
        line_count       <= line_count_next;
        dot_count        <= dot_count_next;
        res_valid        <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each executed command
  always_ff @(posedge clk) begin
    if (pop) begin
      res_data    <= res_data_next;
      res_use_mem <= use_mem;
      res_vblank  <= status_reg_next[VBLANK_BIT];
      res_line    <= line_count_next;
      res_dot     <= dot_count_next;
      res_render  <= (mask_reg_next & MASK_RENDER) != '0;
    end
  end

  // Video store: at most one write or one registered read per command
  always_ff @(posedge clk) begin
    if (pop && vid_we) video_store[vid_waddr] <= cmd.data;
    if (pop && vid_re) mem_q <= video_store[vid_raddr];
  end

  // Sprite store: filled by sprite data writes and DMA bytes
  always_ff @(posedge clk) begin
    if (pop && spr_we) sprite_store[spr_addr] <= spr_wdata;
  end

  assign result.valid             = res_valid;
  assign result.read_data         = res_use_mem ? mem_q : res_data;
  assign result.vblank            = res_vblank;
  assign result.scan_line         = res_line;
  assign result.dot               = res_dot;
  assign result.rendering_enabled = res_render;

`ifndef SYNTHESIS
  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    dot_count <= LAST_DOT)
    else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line_count >= PRE_LINE && line_count <= LastLine)
    else $error("line counter out of range");

  a_vblank_set: assert property (@(posedge clk) disable iff (rst)
    pop && cmd.kind == CMD_TICK && line_count_next == VBLANK_LINE &&
    dot_count_next == FLAG_DOT |=> status_reg[VBLANK_BIT])
    else $error("vblank not raised at its dot");
`endif

endmodule

`default_nettype wire

@@ hdl/picture_unit_registers_and_timing.sv @@
// Top level of the picture unit register block: front end, command queue, back end.
//
//   channel  | dir | transfer moves
//   ---------+-----+-------------------------------------------------------
//   item     | in  | opcode, reg_index, write_data, dma_index/byte/page
//   result   | out | read_data, vblank, scan_line, dot, rendering_enabled
//
// One item per clock sustained while results are taken. An item is written to the
// queue at its transfer edge and executed when the back end pops it, which loads
// the result register (the execute edge also does the single video store access,
// with a registered read).
// Reset is synchronous and clears the control state; the video and sprite stores
// are not cleared and need no sweep.
// A stalled result holds the back end; the two-entry queue keeps taking items
// until it fills, then item.ready drops.
`default_nettype none

module picture_unit_registers_and_timing #(
  parameter int VIDEO_ADDR_BITS = 14,
  parameter int LAST_LINE       = 260
) (
  input  logic      clk,
  input  logic      rst,
  pur_in_if.sink    item,
  pur_out_if.source result
);
  import pur_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  pur_front u_front (
    .item     (item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pur_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pur_back #(
    .VIDEO_ADDR_BITS (VIDEO_ADDR_BITS),
    .LAST_LINE       (LAST_LINE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the picture unit register and timing block.
module testbench;
  import pur_pkg::*;

  localparam int VIDEO_BITS   = 14;
  localparam int FINAL_LINE   = 260;
  localparam logic [2:0] OP_LAST = 3'd7;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;
  localparam int PHASE_ITEMS  = 50;
  localparam int LINE_TICKS   = int'(LAST_DOT) + 1;

  typedef struct packed {
    logic [2:0] opcode;
    reg_sel_t   reg_index;
    logic [7:0] write_data;
    logic [7:0] dma_index;
    logic [7:0] dma_byte;
    logic [7:0] dma_page;
  } bus_item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              vblank;
    logic signed [9:0] scan_line;
    logic [8:0]        dot;
    logic              rendering_enabled;
  } unit_reply_t;

  logic clk = 1'b0;
  logic rst;

  pur_in_if  item_ch ();
  pur_out_if result_ch ();

  picture_unit_registers_and_timing #(
    .VIDEO_ADDR_BITS(VIDEO_BITS),
    .LAST_LINE(FINAL_LINE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block state. Scroll word and sprite store contents never
  // reach a result, so they are not kept.
  logic [7:0]        ctrl_q, mask_q, status_q, oam_addr_q, oam_last_q, latch_q;
  logic [15:0]       vaddr_q;
  logic              first_write_q;
  logic signed [9:0] line_q;
  logic [8:0]        dot_q;
  logic [7:0]        vram_q [int unsigned];

  unit_reply_t replies_due [$];
  int items_sent  = 0;
  int error_count = 0;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_len    = 0;
  int hold_tag    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;

  function automatic logic [15:0] next_vaddr();
    return vaddr_q + (ctrl_q[CTRL_INC32_BIT] ? STEP_WIDE : STEP_NARROW);
  endfunction

  // Advance the mirror by one item and return the result it should produce
  function automatic unit_reply_t step_unit(bus_item_t it);
    unit_reply_t r;
    logic [7:0]  rd;
    logic        is_read;
    rd = '0;
    is_read = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        if (dot_q == LAST_DOT) begin
          dot_q = '0;
          line_q = (line_q == FINAL_LINE) ? PRE_LINE : line_q + 10'sd1;
        end else begin
          dot_q = dot_q + 9'd1;
        end
        if (line_q == VBLANK_LINE && dot_q == FLAG_DOT) begin
          status_q[VBLANK_BIT] = 1'b1;
        end else if (line_q == PRE_LINE && dot_q == FLAG_DOT) begin
          status_q[VBLANK_BIT] = 1'b0;
        end
      end
      OP_READ: begin
        is_read = 1'b1;
        case (it.reg_index)
          REG_STATUS: begin
            rd = status_q;
            first_write_q = 1'b1;
            latch_q = '0;
          end
          REG_OAM_DATA: begin
            latch_q = oam_last_q;
            rd = latch_q;
          end
          REG_DATA: begin
            // address steps before the fetch
            vaddr_q = next_vaddr();
            latch_q = vram_q[vaddr_q[VIDEO_BITS-1:0]];
            rd = latch_q;
          end
          default: rd = latch_q;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_index)
          REG_CTRL:     ctrl_q = it.write_data;
          REG_MASK:     mask_q = it.write_data;
          REG_OAM_ADDR: oam_addr_q = it.write_data;
          REG_OAM_DATA: begin
            oam_last_q = it.write_data;
            oam_addr_q = oam_addr_q + 8'd1;
          end
          REG_SCROLL, REG_ADDR: begin
            // second byte of a pair joins the latch, which holds the high byte
            if (!first_write_q && it.reg_index == REG_ADDR)
              vaddr_q = {latch_q, it.write_data};
            first_write_q = !first_write_q;
          end
          REG_DATA: begin
            vram_q[vaddr_q[VIDEO_BITS-1:0]] = it.write_data;
            vaddr_q = next_vaddr();
          end
          default: ;
        endcase
        latch_q = it.write_data;
      end
      OP_DMA: latch_q = it.dma_page;
      OP_SOFT_RESET: begin
        ctrl_q = '0;
        mask_q = '0;
        status_q = {status_q[VBLANK_BIT], 7'd0};
        latch_q = '0;
        first_write_q = 1'b1;
        line_q = PRE_LINE;
        dot_q = '0;
      end
      default: ;
    endcase
    r.read_data = is_read ? rd : latch_q;
    r.vblank = status_q[VBLANK_BIT];
    r.scan_line = line_q;
    r.dot = dot_q;
    r.rendering_enabled = |(mask_q & MASK_RENDER);
    return r;
  endfunction

  // Offer one item, wait for its transfer, then record the expected result
  task automatic send_item(input bus_item_t it);
    logic [15:0] nxt;
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    // never fetch a video entry that was not written; write it instead
    nxt = next_vaddr();
    if (it.opcode == OP_READ && it.reg_index == REG_DATA && !vram_q.exists(nxt[VIDEO_BITS-1:0]))
      it.opcode = OP_WRITE;
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= it.opcode;
    item_ch.reg_index  <= it.reg_index;
    item_ch.write_data <= it.write_data;
    item_ch.dma_index  <= it.dma_index;
    item_ch.dma_byte   <= it.dma_byte;
    item_ch.dma_page   <= it.dma_page;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    replies_due.push_back(step_unit(it));
    items_sent++;
  endtask

  task automatic issue(input logic [2:0] op, input reg_sel_t sel, input logic [7:0] data);
    bus_item_t it;
    it = '{op, sel, data, 8'($urandom), 8'($urandom), 8'($urandom)};
    send_item(it);
  endtask

  task automatic wait_for_replies();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic set_idle(input int send_gap, input int recv_stall);
    gap_pct = send_gap;
    stall_pct <= recv_stall;
  endtask

  // Random traffic: mostly well-formed register sequences, some noise
  task automatic run_traffic(input int count);
    int          stop_at, n;
    logic [7:0]  hi, lo;
    logic [15:0] back;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      n = $urandom_range(1, 6);
      case ($urandom_range(9))
        0, 1: begin
          // program an address, write a run, rewind and read it back
          issue(OP_WRITE, REG_CTRL, 8'($urandom));
          issue(OP_READ, REG_STATUS, 8'($urandom));
          hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 35));
          lo = 8'($urandom);
          issue(OP_WRITE, REG_ADDR, hi);
          issue(OP_WRITE, REG_ADDR, lo);
          repeat (n) issue(OP_WRITE, REG_DATA, 8'($urandom));
          back = {hi, lo} - (ctrl_q[CTRL_INC32_BIT] ? STEP_WIDE : STEP_NARROW);
          issue(OP_WRITE, REG_ADDR, back[15:8]);
          issue(OP_WRITE, REG_ADDR, back[7:0]);
          repeat (n) issue(OP_READ, REG_DATA, 8'($urandom));
        end
        2: begin
          issue(OP_WRITE, REG_OAM_ADDR, 8'($urandom));
          repeat (n) issue(OP_WRITE, REG_OAM_DATA, 8'($urandom));
          issue(OP_READ, REG_OAM_DATA, 8'($urandom));
        end
        3: begin
          issue(OP_READ, REG_STATUS, 8'($urandom));
          issue(OP_WRITE, REG_SCROLL, 8'($urandom));
          issue(OP_WRITE, REG_SCROLL, 8'($urandom));
        end
        4, 5: repeat ($urandom_range(1, 40)) issue(OP_TICK, reg_sel_t'(3'($urandom)), 8'($urandom));
        6: begin
          issue(OP_WRITE, $urandom_range(1) ? REG_CTRL : REG_MASK, 8'($urandom));
          issue(OP_READ, reg_sel_t'(3'($urandom)), 8'($urandom));
        end
        7: repeat (n) issue(OP_DMA, reg_sel_t'(3'($urandom)), 8'($urandom));
        8: begin
          // noise: any opcode, soft reset and unused codes included
          repeat (n) issue(3'($urandom), reg_sel_t'(3'($urandom)), 8'($urandom));
        end
        default: begin
          // broken pair: a lone address byte leaves the toggle half way
          issue(OP_WRITE, REG_ADDR, 8'($urandom));
          repeat (n) issue(OP_WRITE, REG_DATA, 8'($urandom));
        end
      endcase
    end
  endtask

  // Every register written, several read, field extremes, unused opcodes, soft reset
  task automatic test_register_access();
    set_idle(0, 0);
    issue(OP_READ, REG_STATUS, 8'h00);
    issue(OP_WRITE, REG_CTRL, 8'hFF);     // 32-entry address step
    issue(OP_WRITE, REG_MASK, 8'h04);
    issue(OP_WRITE, REG_ADDR, 8'hFF);
    issue(OP_WRITE, REG_ADDR, 8'hFE);
    issue(OP_WRITE, REG_DATA, 8'h00);     // address wraps past 16 bits
    issue(OP_WRITE, REG_CTRL, 8'h00);
    issue(OP_WRITE, REG_MASK, 8'h10);
    issue(OP_WRITE, REG_ADDR, 8'hFF);
    issue(OP_WRITE, REG_ADDR, 8'hFD);
    issue(OP_READ, REG_DATA, 8'h00);
    issue(OP_WRITE, REG_OAM_ADDR, 8'hFF);
    issue(OP_WRITE, REG_OAM_DATA, 8'h5A); // sprite address wraps
    issue(OP_READ, REG_OAM_DATA, 8'h00);
    issue(OP_WRITE, REG_SCROLL, 8'h00);
    issue(OP_WRITE, REG_SCROLL, 8'hFF);
    issue(OP_WRITE, REG_STATUS, 8'h3C);   // only the latch moves
    issue(OP_READ, REG_MASK, 8'h00);
    send_item('{OP_DMA, REG_CTRL, 8'h00, 8'hFF, 8'h00, 8'hFF});
    send_item('{OP_DMA, REG_DATA, 8'hFF, 8'h00, 8'hFF, 8'h00});
    for (int op = OP_SOFT_RESET + 1; op <= OP_LAST; op++)
      issue(3'(op), REG_STATUS, 8'hFF);
    issue(OP_SOFT_RESET, REG_CTRL, 8'h00);
    issue(OP_READ, REG_STATUS, 8'h00);
    wait_for_replies();
  endtask

  // Pre-render dot 1 clear, a full line into the next one, status read and soft reset
  task automatic test_frame_timing();
    set_idle(0, 0);
    issue(OP_SOFT_RESET, REG_CTRL, 8'h00);
    issue(OP_TICK, REG_CTRL, 8'h00);      // pre-render dot 1 clears vblank
    set_idle(9, 9);
    repeat (LINE_TICKS) issue(OP_TICK, reg_sel_t'(3'($urandom)), 8'($urandom));
    issue(OP_READ, REG_STATUS, 8'h00);
    issue(OP_SOFT_RESET, REG_CTRL, 8'h00);
    issue(OP_TICK, REG_CTRL, 8'h00);
    wait_for_replies();
  endtask

  task automatic test_random_traffic();
    set_idle(0, 0);
    run_traffic(PHASE_ITEMS);
    set_idle(72, 0);
    run_traffic(PHASE_ITEMS);
    set_idle(0, 72);
    run_traffic(PHASE_ITEMS);
    set_idle(9, 9);
    run_traffic(PHASE_ITEMS);
    wait_for_replies();
  endtask

  // Long result stall while items keep coming, so the queue fills
  task automatic test_backpressure();
    set_idle(0, 0);
    hold_len <= 64;
    hold_tag <= hold_tag + 1;
    run_traffic(30);
    wait_for_replies();
  endtask

  task automatic compare_field(input string name, input logic signed [15:0] want, got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // Result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    unit_reply_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (replies_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with none expected, read_data %0d", $time,
                     result_ch.read_data);
        end else begin
          want = replies_due.pop_front();
          compare_field("read_data", want.read_data, result_ch.read_data);
          compare_field("vblank", want.vblank, result_ch.vblank);
          compare_field("scan_line", want.scan_line, result_ch.scan_line);
          compare_field("dot", want.dot, result_ch.dot);
          compare_field("rendering_enabled", want.rendering_enabled,
                        result_ch.rendering_enabled);
        end
      end
      if (hold_tag != hold_ack) begin
        hold_left = hold_len;
        hold_ack = hold_tag;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** picture_unit_registers_and_timing: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_TICK;
    item_ch.reg_index = REG_CTRL;
    item_ch.write_data = '0;
    item_ch.dma_index = '0;
    item_ch.dma_byte = '0;
    item_ch.dma_page = '0;
    result_ch.ready = 1'b0;
    ctrl_q = '0;
    mask_q = '0;
    status_q = STATUS_RESET;
    oam_addr_q = '0;
    oam_last_q = '0;
    latch_q = '0;
    vaddr_q = '0;
    first_write_q = 1'b1;
    line_q = PRE_LINE;
    dot_q = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_frame_timing();
    test_random_traffic();
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** picture_unit_registers_and_timing: PASSED **");
    end else begin
      $display("** picture_unit_registers_and_timing: FAILED **");
    end
    $finish;
  end

endmodule
